// File: rtl/stoq_pkg.sv
// Package for the stable time-ordered event queue.
// Holds the queue depth, field widths, request and status codes, register indexes,
// and the control types shared by the controller, the datapath and the top level.
`default_nettype none

package stoq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W      = 63;
    localparam int CODE_W      = 8;
    localparam int TAG_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_CODE_A = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_B = CFG_INDEX_W'(1);

    localparam logic [CODE_W-1:0] CODE_A_RESET = 8'd0;
    localparam logic [CODE_W-1:0] CODE_B_RESET = 8'd1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic execute;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_flags;

endpackage

`default_nettype wire

// File: rtl/stoq_ctrl.sv
// Controller state machine of the event queue.
// Depends on stoq_pkg; issues load and execute commands to stoq_dpath.
`default_nettype none

module stoq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  stoq_pkg::t_dp_flags i_flags,
    output stoq_pkg::t_cmd      o_cmd
);

    stoq_pkg::t_state r_state;
    stoq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stoq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stoq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = stoq_pkg::S_EXEC;
                end
            end
            stoq_pkg::S_EXEC: begin
                // A finished request frees the input register for the next one.
                if (i_flags.out_free && !i_in_valid) begin
                    n_state = stoq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stoq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            stoq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            stoq_pkg::S_EXEC: begin
                o_in_ready    = i_flags.out_free;
                o_cmd.execute = i_flags.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        // No request is taken while reset is held.
        o_in_ready    = o_in_ready && i_rst_n;
        o_cmd.load_in = i_in_valid && o_in_ready;
    end

endmodule

`default_nettype wire

// File: rtl/stoq_dpath.sv
// Datapath of the event queue: request register, sorted row of shift cells,
// event counts, configuration registers and the output register.
// Depends on stoq_pkg; driven by stoq_ctrl.
`default_nettype none

module stoq_dpath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  stoq_pkg::t_cmd                       i_cmd,
    output stoq_pkg::t_dp_flags                  o_flags,
    input  wire                                  i_req_type,
    input  wire  [stoq_pkg::TIME_W-1:0]          i_event_time,
    input  wire  [stoq_pkg::CODE_W-1:0]          i_event_code,
    input  wire  [stoq_pkg::TAG_W-1:0]           i_payload_tag,
    input  wire                                  i_cfg_valid,
    input  wire  [stoq_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [stoq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [stoq_pkg::STATUS_W-1:0]        o_status,
    output logic [stoq_pkg::TIME_W-1:0]          o_out_time,
    output logic [stoq_pkg::CODE_W-1:0]          o_out_code,
    output logic [stoq_pkg::TAG_W-1:0]           o_out_tag,
    output logic [stoq_pkg::COUNT_W-1:0]         o_cyclic_count,
    output logic [stoq_pkg::COUNT_W-1:0]         o_other_count
);

    // Captured request.
    logic                          r_in_req;
    logic [stoq_pkg::TIME_W-1:0]   r_in_time;
    logic [stoq_pkg::CODE_W-1:0]   r_in_code;
    logic [stoq_pkg::TAG_W-1:0]    r_in_tag;

    // Sorted cells, earliest event in cell 0.
    logic [stoq_pkg::TIME_W-1:0]   r_time [stoq_pkg::QUEUE_DEPTH];
    logic [stoq_pkg::CODE_W-1:0]   r_code [stoq_pkg::QUEUE_DEPTH];
    logic [stoq_pkg::TAG_W-1:0]    r_tag  [stoq_pkg::QUEUE_DEPTH];
    logic [stoq_pkg::TIME_W-1:0]   n_time [stoq_pkg::QUEUE_DEPTH];
    logic [stoq_pkg::CODE_W-1:0]   n_code [stoq_pkg::QUEUE_DEPTH];
    logic [stoq_pkg::TAG_W-1:0]    n_tag  [stoq_pkg::QUEUE_DEPTH];

    logic [stoq_pkg::OCC_W-1:0]    r_occ;
    logic [stoq_pkg::OCC_W-1:0]    r_cyc;
    logic [stoq_pkg::OCC_W-1:0]    r_oth;
    logic [stoq_pkg::OCC_W-1:0]    n_occ;
    logic [stoq_pkg::OCC_W-1:0]    n_cyc;
    logic [stoq_pkg::OCC_W-1:0]    n_oth;

    logic [stoq_pkg::CODE_W-1:0]   r_code_a;
    logic [stoq_pkg::CODE_W-1:0]   r_code_b;

    logic                          r_out_valid;
    logic [stoq_pkg::STATUS_W-1:0] r_status;
    logic [stoq_pkg::TIME_W-1:0]   r_out_time;
    logic [stoq_pkg::CODE_W-1:0]   r_out_code;
    logic [stoq_pkg::TAG_W-1:0]    r_out_tag;
    logic [stoq_pkg::COUNT_W-1:0]  r_cyc_out;
    logic [stoq_pkg::COUNT_W-1:0]  r_oth_out;

    logic [stoq_pkg::STATUS_W-1:0] n_status;
    logic [stoq_pkg::TIME_W-1:0]   n_out_time;
    logic [stoq_pkg::CODE_W-1:0]   n_out_code;
    logic [stoq_pkg::TAG_W-1:0]    n_out_tag;

    logic [stoq_pkg::QUEUE_DEPTH-1:0] w_le;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_new_cyc;
    logic                          w_head_cyc;

    assign w_full     = (r_occ == stoq_pkg::OCC_W'(stoq_pkg::QUEUE_DEPTH));
    assign w_empty    = (r_occ == '0);
    assign w_new_cyc  = (r_in_code == r_code_a) || (r_in_code == r_code_b);
    assign w_head_cyc = (r_code[0] == r_code_a) || (r_code[0] == r_code_b);

    // Each occupied cell whose time is not later than the new one keeps its place.
    always_comb begin
        for (int i = 0; i < stoq_pkg::QUEUE_DEPTH; i++) begin
            w_le[i] = (stoq_pkg::OCC_W'(i) < r_occ) && (r_time[i] <= r_in_time);
        end
    end

    always_comb begin
        logic                        prev_le;
        logic [stoq_pkg::TIME_W-1:0] prev_time;
        logic [stoq_pkg::CODE_W-1:0] prev_code;
        logic [stoq_pkg::TAG_W-1:0]  prev_tag;
        prev_le    = 1'b1;
        prev_time  = '0;
        prev_code  = '0;
        prev_tag   = '0;
        n_occ      = r_occ;
        n_cyc      = r_cyc;
        n_oth      = r_oth;
        n_status   = stoq_pkg::ST_OK;
        n_out_time = '0;
        n_out_code = '0;
        n_out_tag  = '0;
        for (int i = 0; i < stoq_pkg::QUEUE_DEPTH; i++) begin
            n_time[i] = r_time[i];
            n_code[i] = r_code[i];
            n_tag[i]  = r_tag[i];
        end

        if (r_in_req == stoq_pkg::REQ_INSERT) begin
            if (w_full) begin
                n_status = stoq_pkg::ST_FULL;
            end else begin
                // The first cell past the run of earlier-or-equal times takes the
                // new event; every cell behind it takes its upper neighbor.
                for (int i = 0; i < stoq_pkg::QUEUE_DEPTH; i++) begin
                    if (!w_le[i]) begin
                        if (prev_le) begin
                            n_time[i] = r_in_time;
                            n_code[i] = r_in_code;
                            n_tag[i]  = r_in_tag;
                        end else begin
                            n_time[i] = prev_time;
                            n_code[i] = prev_code;
                            n_tag[i]  = prev_tag;
                        end
                    end
                    prev_le   = w_le[i];
                    prev_time = r_time[i];
                    prev_code = r_code[i];
                    prev_tag  = r_tag[i];
                end
                n_occ = r_occ + 1'b1;
                if (w_new_cyc) begin
                    n_cyc = r_cyc + 1'b1;
                end else begin
                    n_oth = r_oth + 1'b1;
                end
            end
        end else begin
            if (w_empty) begin
                n_status = stoq_pkg::ST_EMPTY;
            end else begin
                n_out_time = r_time[0];
                n_out_code = r_code[0];
                n_out_tag  = r_tag[0];
                for (int i = 0; i < stoq_pkg::QUEUE_DEPTH - 1; i++) begin
                    n_time[i] = r_time[i+1];
                    n_code[i] = r_code[i+1];
                    n_tag[i]  = r_tag[i+1];
                end
                n_occ = r_occ - 1'b1;
                // The counts saturate at zero when the codes changed while queued.
                if (w_head_cyc) begin
                    if (r_cyc != '0) begin
                        n_cyc = r_cyc - 1'b1;
                    end
                end else begin
                    if (r_oth != '0) begin
                        n_oth = r_oth - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_req  <= i_req_type;
            r_in_time <= i_event_time;
            r_in_code <= i_event_code;
            r_in_tag  <= i_payload_tag;
        end
        if (i_cmd.execute) begin
            for (int i = 0; i < stoq_pkg::QUEUE_DEPTH; i++) begin
                r_time[i] <= n_time[i];
                r_code[i] <= n_code[i];
                r_tag[i]  <= n_tag[i];
            end
            r_status   <= n_status;
            r_out_time <= n_out_time;
            r_out_code <= n_out_code;
            r_out_tag  <= n_out_tag;
            r_cyc_out  <= stoq_pkg::COUNT_W'(n_cyc);
            r_oth_out  <= stoq_pkg::COUNT_W'(n_oth);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_cyc       <= '0;
            r_oth       <= '0;
            r_code_a    <= stoq_pkg::CODE_A_RESET;
            r_code_b    <= stoq_pkg::CODE_B_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_occ       <= n_occ;
                r_cyc       <= n_cyc;
                r_oth       <= n_oth;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    stoq_pkg::REG_CODE_A: r_code_a <= i_cfg_data;
                    stoq_pkg::REG_CODE_B: r_code_b <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_flags.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_time     = r_out_time;
    assign o_out_code     = r_out_code;
    assign o_out_tag      = r_out_tag;
    assign o_cyclic_count = r_cyc_out;
    assign o_other_count  = r_oth_out;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= stoq_pkg::OCC_W'(stoq_pkg::QUEUE_DEPTH))
        else $error("occupancy exceeds queue depth");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ >= stoq_pkg::OCC_W'(2)) |-> (r_time[0] <= r_time[1]))
        else $error("head cells out of time order");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && (r_in_req == stoq_pkg::REQ_INSERT) && w_full)
        |=> (r_occ == $past(r_occ)))
        else $error("insert into full queue changed occupancy");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && (r_in_req == stoq_pkg::REQ_POP) && !w_empty)
        |=> (r_occ == stoq_pkg::OCC_W'($past(r_occ) - 1'b1)))
        else $error("pop did not remove exactly one event");

    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> (r_out_valid && (r_status != 2'd3)))
        else $error("executed request produced no valid result");

endmodule

`default_nettype wire

// File: rtl/stable_time_ordered_event_queue.sv
// Stable time-ordered event queue: one result per request, status plus counts.
// Flow: an accepted request is held in the input register, then executed into the
// output register. Throughput: one request per cycle while results are taken; a request
// waits in its input register while the output register holds an untaken result.
// Reset (synchronous, active low) empties the queue, clears the counts and restores
// the cyclic codes to 0 and 1; the slot contents are not cleared.
`default_nettype none

module stable_time_ordered_event_queue (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_req_type,
    input  wire  [stoq_pkg::TIME_W-1:0]      i_event_time,
    input  wire  [stoq_pkg::CODE_W-1:0]      i_event_code,
    input  wire  [stoq_pkg::TAG_W-1:0]       i_payload_tag,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [stoq_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [stoq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [stoq_pkg::STATUS_W-1:0]    o_status,
    output logic [stoq_pkg::TIME_W-1:0]      o_out_time,
    output logic [stoq_pkg::CODE_W-1:0]      o_out_code,
    output logic [stoq_pkg::TAG_W-1:0]       o_out_tag,
    output logic [stoq_pkg::COUNT_W-1:0]     o_cyclic_count,
    output logic [stoq_pkg::COUNT_W-1:0]     o_other_count
);

    stoq_pkg::t_cmd      w_cmd;
    stoq_pkg::t_dp_flags w_flags;

    // Configuration writes are taken in any cycle outside reset.
    assign o_cfg_ready = i_rst_n;

    stoq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    stoq_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_flags        (w_flags),
        .i_req_type     (i_req_type),
        .i_event_time   (i_event_time),
        .i_event_code   (i_event_code),
        .i_payload_tag  (i_payload_tag),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_time     (o_out_time),
        .o_out_code     (o_out_code),
        .o_out_tag      (o_out_tag),
        .o_cyclic_count (o_cyclic_count),
        .o_other_count  (o_other_count)
    );

endmodule

`default_nettype wire
